// ===== rtl/fss_pkg.sv =====
`default_nettype none

package fss_pkg;

    localparam int QUERY_CHARS_DEF = 16;
    localparam int MAX_PHRASE_DEF  = 255;

    // Configuration register indexes.
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 64;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_HIGH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QUERY_COUNT = 2'd2;

    localparam int CHAR_W   = 8;
    localparam int COUNT_W  = 5;
    localparam int TOTAL_W  = 9;
    localparam int BONUS_W  = 5;
    localparam int SCORE_W  = 10;
    localparam int MOD6_W   = 3;

    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CHAR_UP_A  = 8'h41;
    localparam logic [CHAR_W-1:0] CHAR_UP_Z  = 8'h5A;
    localparam logic [CHAR_W-1:0] CASE_STEP  = 8'h20;

    localparam logic [TOTAL_W-1:0] WORD_START_PTS = 9'd12;
    localparam logic [TOTAL_W-1:0] INNER_PTS      = 9'd3;
    localparam logic [BONUS_W-1:0] BONUS_STEP     = 5'd2;
    localparam logic [BONUS_W-1:0] BONUS_MAX      = 5'd30;
    localparam logic [MOD6_W-1:0]  LEN_DIV_LAST   = 3'd5;
    localparam int                 CATEGORY_PEN   = 6;
    localparam int                 SCORE_MIN      = -512;

    typedef struct packed {
        logic [CHAR_W-1:0] phrase_char;
        logic              phrase_first;
        logic              phrase_last;
        logic              is_category;
    } t_item;

    typedef struct packed {
        logic                      matched;
        logic signed [SCORE_W-1:0] score;
    } t_result;

    // ASCII case fold: only 'A'..'Z' move down to 'a'..'z'.
    function automatic logic [CHAR_W-1:0] fold(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= CHAR_UP_A && c <= CHAR_UP_Z) begin
            r = c + CASE_STEP;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/fuzzy_subsequence_scorer_core.sv =====
`default_nettype none

// Channel   Direction  Signals                         Payload
// s         in         i_s_tvalid/o_s_tready           tdata: phrase_char; tuser: first, category;
//                                                      tlast: last character
// m         out        o_m_tvalid/i_m_tready           tdata: score; tuser: matched
// cfg       in         i_cfg_we/i_cfg_idx/i_cfg_data   query registers, no read-back
//
// One character beat is taken every cycle unless a last beat is held. Each beat sits in the input
// register, where the match logic scores it against the running state.
// A result is registered when its last beat leaves the input register, and is then valid on m.
// Only a last beat waits on a full result register; other beats never stall.
// Reset is synchronous; s is not ready while reset is asserted.
module fuzzy_subsequence_scorer_core #(
    parameter int QUERY_CHARS = fss_pkg::QUERY_CHARS_DEF,
    parameter int MAX_PHRASE  = fss_pkg::MAX_PHRASE_DEF
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [7:0]                     i_s_tdata,  // [7:0] phrase_char
    input  wire logic [1:0]                     i_s_tuser,  // [0] phrase_first, [1] is_category
    input  wire logic                           i_s_tlast,
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic [15:0]                         o_m_tdata,  // [9:0] score, [15:10] zero
    output logic                                o_m_tuser,  // [0] matched
    input  wire logic                           i_cfg_we,
    input  wire logic [fss_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int POS_W = $clog2(QUERY_CHARS + 1);

    logic [QUERY_CHARS-1:0][fss_pkg::CHAR_W-1:0] qchar;
    logic [QUERY_CHARS-1:0]                      nonspace;
    logic [POS_W-1:0]                            qcount;

    logic             r_in_valid;
    fss_pkg::t_item   r_in;
    logic             r_out_valid;
    fss_pkg::t_result r_out;
    fss_pkg::t_result res;
    logic             adv;

    fss_query #(
        .QUERY_CHARS (QUERY_CHARS),
        .POS_W       (POS_W)
    ) u_query (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_qchar    (qchar),
        .o_nonspace (nonspace),
        .o_count    (qcount)
    );

    fss_engine #(
        .QUERY_CHARS (QUERY_CHARS),
        .MAX_PHRASE  (MAX_PHRASE),
        .POS_W       (POS_W)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (adv),
        .i_item     (r_in),
        .i_qchar    (qchar),
        .i_nonspace (nonspace),
        .i_count    (qcount),
        .o_res      (res)
    );

    // A held beat moves on unless it carries a result and the result register is stuck.
    assign adv        = r_in_valid && (!r_in.phrase_last || !r_out_valid || i_m_tready);
    assign o_s_tready = i_rst_n && (!r_in_valid || adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_s_tvalid && o_s_tready) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in.phrase_char  <= i_s_tdata;
            r_in.phrase_first <= i_s_tuser[0];
            r_in.phrase_last  <= i_s_tlast;
            r_in.is_category  <= i_s_tuser[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_in.phrase_last) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_in.phrase_last) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_out.matched;
    assign o_m_tdata  = {6'b0, r_out.score};

`ifndef ASSERT_OFF
    a_inner_no_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !r_in.phrase_last |-> adv)
        else $error("non-final beat held back");

    a_last_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.phrase_last |=> o_m_tvalid)
        else $error("final beat left no result");

    a_stall_holds_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("stalled beat lost from input register");
`endif

endmodule

`default_nettype wire

// ===== rtl/fss_query.sv =====
`default_nettype none

module fss_query #(
    parameter int QUERY_CHARS = fss_pkg::QUERY_CHARS_DEF,
    parameter int POS_W       = $clog2(QUERY_CHARS + 1)
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [fss_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  wire logic [fss_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output logic [QUERY_CHARS-1:0][fss_pkg::CHAR_W-1:0] o_qchar,
    output logic [QUERY_CHARS-1:0]                o_nonspace,
    output logic [POS_W-1:0]                      o_count
);

    logic [fss_pkg::CFG_DATA_W-1:0] r_qlow;
    logic [fss_pkg::CFG_DATA_W-1:0] r_qhigh;
    logic [fss_pkg::COUNT_W-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlow  <= '0;
            r_qhigh <= '0;
            r_count <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                fss_pkg::REG_QUERY_LOW:   r_qlow  <= i_cfg_data;
                fss_pkg::REG_QUERY_HIGH:  r_qhigh <= i_cfg_data;
                fss_pkg::REG_QUERY_COUNT: r_count <= i_cfg_data[fss_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Counts above the query capacity behave as a full query.
    assign o_count = (r_count > fss_pkg::COUNT_W'(QUERY_CHARS))
                     ? POS_W'(QUERY_CHARS) : POS_W'(r_count);

    for (genvar gi = 0; gi < QUERY_CHARS; gi++) begin : g_char
        logic [fss_pkg::CHAR_W-1:0] raw;
        if (gi < 8) begin : g_low
            assign raw = r_qlow[gi*8 +: 8];
        end else begin : g_high
            assign raw = r_qhigh[(gi-8)*8 +: 8];
        end
        assign o_qchar[gi]    = fss_pkg::fold(raw);
        assign o_nonspace[gi] = (raw != fss_pkg::CHAR_SPACE) && (POS_W'(gi) < o_count);
    end

endmodule

`default_nettype wire

// ===== rtl/fss_engine.sv =====
`default_nettype none

module fss_engine #(
    parameter int QUERY_CHARS = fss_pkg::QUERY_CHARS_DEF,
    parameter int MAX_PHRASE  = fss_pkg::MAX_PHRASE_DEF,
    parameter int POS_W       = $clog2(QUERY_CHARS + 1)
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire logic                                   i_adv,
    input  wire fss_pkg::t_item                         i_item,
    input  wire logic [QUERY_CHARS-1:0][fss_pkg::CHAR_W-1:0] i_qchar,
    input  wire logic [QUERY_CHARS-1:0]                 i_nonspace,
    input  wire logic [POS_W-1:0]                       i_count,
    output fss_pkg::t_result                            o_res
);

    localparam int LEN_W = $clog2(MAX_PHRASE + 1);
    localparam int IDX_W = (QUERY_CHARS > 1) ? $clog2(QUERY_CHARS) : 1;
    localparam int SW    = ((LEN_W > fss_pkg::TOTAL_W) ? LEN_W : fss_pkg::TOTAL_W) + 2;
    localparam logic signed [SW-1:0] SMIN = SW'(fss_pkg::SCORE_MIN);

    logic [POS_W-1:0]            r_pos, n_pos;
    logic [fss_pkg::BONUS_W-1:0] r_bonus, n_bonus;
    logic [fss_pkg::TOTAL_W-1:0] r_total, n_total;
    logic                        r_sep, n_sep;
    logic [LEN_W-1:0]            r_len, n_len;
    logic [fss_pkg::MOD6_W-1:0]  r_mod6, n_mod6;
    logic [LEN_W-1:0]            r_div6, n_div6;

    logic [POS_W-1:0]            cur_pos, pos_c, idx;
    logic [fss_pkg::BONUS_W-1:0] cur_bonus;
    logic [fss_pkg::TOTAL_W-1:0] cur_total;
    logic                        cur_sep;
    logic [LEN_W-1:0]            cur_len, cur_div6;
    logic [fss_pkg::MOD6_W-1:0]  cur_mod6;
    logic                        found, hit, remain;
    logic signed [SW-1:0]        s_raw;

    always_comb begin
        // A first mark starts from the cleared state.
        cur_pos   = i_item.phrase_first ? '0 : r_pos;
        cur_bonus = i_item.phrase_first ? '0 : r_bonus;
        cur_total = i_item.phrase_first ? '0 : r_total;
        cur_sep   = i_item.phrase_first ? 1'b1 : r_sep;
        cur_len   = i_item.phrase_first ? '0 : r_len;
        cur_mod6  = i_item.phrase_first ? '0 : r_mod6;
        cur_div6  = i_item.phrase_first ? '0 : r_div6;

        pos_c = (cur_pos > i_count) ? i_count : cur_pos;

        // Next non-space query character at or after the position.
        idx   = i_count;
        found = 1'b0;
        for (int i = QUERY_CHARS - 1; i >= 0; i--) begin
            if (POS_W'(i) >= pos_c && i_nonspace[i]) begin
                idx   = POS_W'(i);
                found = 1'b1;
            end
        end

        hit = found && (fss_pkg::fold(i_item.phrase_char) == i_qchar[idx[IDX_W-1:0]]);

        n_total = cur_total;
        n_bonus = cur_bonus;
        n_pos   = i_count;
        if (found) begin
            if (hit) begin
                n_total = cur_total + (cur_sep ? fss_pkg::WORD_START_PTS : fss_pkg::INNER_PTS)
                          + fss_pkg::TOTAL_W'(cur_bonus);
                n_bonus = (cur_bonus >= fss_pkg::BONUS_MAX) ? fss_pkg::BONUS_MAX
                          : cur_bonus + fss_pkg::BONUS_STEP;
                n_pos   = idx + POS_W'(1);
            end else begin
                n_bonus = '0;
                n_pos   = idx;
            end
        end

        n_sep = (i_item.phrase_char == fss_pkg::CHAR_SPACE) ||
                (i_item.phrase_char == fss_pkg::CHAR_SLASH);

        // The length divided by six is kept as a running quotient and remainder.
        n_len  = cur_len;
        n_mod6 = cur_mod6;
        n_div6 = cur_div6;
        if (cur_len < LEN_W'(MAX_PHRASE)) begin
            n_len = cur_len + LEN_W'(1);
            if (cur_mod6 == fss_pkg::LEN_DIV_LAST) begin
                n_mod6 = '0;
                n_div6 = cur_div6 + LEN_W'(1);
            end else begin
                n_mod6 = cur_mod6 + fss_pkg::MOD6_W'(1);
            end
        end

        remain = 1'b0;
        for (int i = 0; i < QUERY_CHARS; i++) begin
            if (POS_W'(i) >= n_pos && i_nonspace[i]) begin
                remain = 1'b1;
            end
        end

        if (i_count == '0) begin
            s_raw = '0;
        end else begin
            s_raw = signed'(SW'(n_total) - SW'(n_div6));
        end
        if (i_item.is_category) begin
            s_raw = s_raw - SW'(fss_pkg::CATEGORY_PEN);
        end
        if (s_raw < SMIN) begin
            s_raw = SMIN;
        end

        o_res.matched = !remain;
        o_res.score   = s_raw[fss_pkg::SCORE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_adv && i_item.phrase_last)) begin
            r_pos   <= '0;
            r_bonus <= '0;
            r_total <= '0;
            r_sep   <= 1'b1;
            r_len   <= '0;
            r_mod6  <= '0;
            r_div6  <= '0;
        end else if (i_adv) begin
            r_pos   <= n_pos;
            r_bonus <= n_bonus;
            r_total <= n_total;
            r_sep   <= n_sep;
            r_len   <= n_len;
            r_mod6  <= n_mod6;
            r_div6  <= n_div6;
        end
    end

`ifndef ASSERT_OFF
    a_mod6_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mod6 <= fss_pkg::LEN_DIV_LAST)
        else $error("length remainder out of range");

    a_bonus_even: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_bonus <= fss_pkg::BONUS_MAX) && (r_bonus[0] == 1'b0))
        else $error("run bonus not even or above its cap");

    a_clear_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_adv && i_item.phrase_last |=> (r_pos == '0) && (r_total == '0) && (r_len == '0))
        else $error("running state not cleared after last beat");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_W'(QUERY_CHARS))
        else $error("query position beyond capacity");
`endif

endmodule

`default_nettype wire
